>>> rtl/core/dbf_pkg.sv
package dbf_pkg;

    localparam int RADIUS      = 3;
    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int EXP_ENTRIES = 256;

    localparam int STORE_ROWS = 2 * RADIUS + 2;
    localparam int WIN        = 2 * RADIUS + 1;
    localparam int TAPS       = WIN * WIN;

    localparam int CW    = $clog2(MAX_WIDTH + 1);
    localparam int RW    = $clog2(MAX_HEIGHT + 1);
    localparam int SW    = $clog2(STORE_ROWS);
    localparam int AW    = $clog2(STORE_ROWS * MAX_WIDTH);
    localparam int TW    = $clog2(WIN);
    localparam int EB    = $clog2(EXP_ENTRIES);
    localparam int D2_W  = $clog2(2 * RADIUS * RADIUS + 1);
    localparam int CNT_W = CW + RW;

    localparam int DW    = 16;
    localparam int QW    = 16;
    localparam int WT_W  = 17;
    localparam int NUM_W = 33 + $clog2(TAPS);
    localparam int DEN_W = 18 + $clog2(TAPS);
    localparam int REM_W = NUM_W + 1;

    localparam int MA_W = 32;
    localparam int MB_W = 24;
    localparam int MP_W = MA_W + MB_W;
    localparam int E_W  = MP_W + 1;
    localparam int E_LIMIT_BIT = 28;

    localparam int CFG_IW = 8;
    localparam int CFG_DW = 24;

    localparam logic [10:0] RST_FRAME_WIDTH   = 11'd640;
    localparam logic [10:0] RST_FRAME_HEIGHT  = 11'd480;
    localparam logic [15:0] RST_SPATIAL_COEFF = 16'd14564;
    localparam logic [23:0] RST_DEPTH_COEFF   = 24'd9321;

    typedef enum logic [CFG_IW-1:0] {
        CFG_FRAME_WIDTH   = 8'd0,
        CFG_FRAME_HEIGHT  = 8'd1,
        CFG_SPATIAL_COEFF = 8'd2,
        CFG_DEPTH_COEFF   = 8'd3
    } t_cfg_reg;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_WRITE,
        ST_COUNT,
        ST_DECIDE,
        ST_CREAD,
        ST_CDATA,
        ST_TADDR,
        ST_TDATA,
        ST_TSQ,
        ST_TDEP,
        ST_TSPA,
        ST_TLUT,
        ST_TMUL,
        ST_TACC,
        ST_DIV,
        ST_DWAIT,
        ST_FIN
    } t_state;

    typedef logic [WT_W-1:0] t_exp_rom [EXP_ENTRIES];

    // long division by shift and subtract, elaboration time only
    function automatic longint unsigned udiv64(input longint unsigned a,
                                               input longint unsigned b);
        longint unsigned q;
        longint unsigned r;
        q = 0;
        r = 0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[62:0], a[i]};
            if (r >= b) begin
                r    = r - b;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // 65536 * exp(-16k/EXP_ENTRIES): Taylor series in Q30, then four squarings
    function automatic t_exp_rom build_exp_rom();
        t_exp_rom          rom;
        longint            sum;
        longint unsigned   term;
        longint unsigned   n;
        longint unsigned   s;
        bit                run;
        for (int k = 0; k < EXP_ENTRIES; k++) begin
            sum  = 0;
            term = 64'd1 << 30;
            n    = 0;
            run  = 1'b1;
            for (int j = 0; j < 64; j++) begin
                if (run) begin
                    if (n[0]) sum = sum - longint'(term);
                    else      sum = sum + longint'(term);
                    n    = n + 1;
                    term = udiv64(term * longint'(k), longint'(EXP_ENTRIES) * n);
                    if (term == 0) run = 1'b0;
                end
            end
            s = (sum > 0) ? longint'(sum) : 64'd0;
            for (int i = 0; i < 4; i++) begin
                s = (s * s + (64'd1 << 29)) >> 30;
            end
            rom[k] = WT_W'((s + (64'd1 << 13)) >> 14);
        end
        return rom;
    endfunction

    localparam t_exp_rom EXP_ROM = build_exp_rom();

    function automatic logic [AW-1:0] store_addr(input logic [SW-1:0] slot,
                                                 input logic [CW-1:0] col);
        return AW'(slot) * AW'(MAX_WIDTH) + AW'(col);
    endfunction

endpackage

>>> rtl/core/dbf_ram.sv
module dbf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/dbf_mul.sv
module dbf_mul
    import dbf_pkg::*;
(
    input  logic            i_clk,
    input  logic [MA_W-1:0] i_a,
    input  logic [MB_W-1:0] i_b,
    output logic [MP_W-1:0] o_p
);

    logic [MP_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= MP_W'(i_a) * MP_W'(i_b);
    end

    assign o_p = r_p;

endmodule

>>> rtl/core/dbf_div.sv
module dbf_div
    import dbf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_busy,
    output logic [QW-1:0]    o_quot
);

    localparam int CNT_B = $clog2(QW + 1);

    logic [REM_W-1:0] r_rem;
    logic [REM_W-1:0] r_dvs;
    logic [QW-1:0]    r_q;
    logic [CNT_B-1:0] r_cnt;
    logic             w_ge;

    assign w_ge = (r_rem >= r_dvs);

    // restoring division, one quotient bit a cycle, rounded by adding den/2 first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_B'(QW);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - CNT_B'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= REM_W'(i_num) + REM_W'(i_den >> 1);
            r_dvs <= REM_W'(i_den) << (QW - 1);
            r_q   <= '0;
        end else if (r_cnt != '0) begin
            if (w_ge) begin
                r_rem <= r_rem - r_dvs;
            end
            r_dvs <= r_dvs >> 1;
            r_q   <= {r_q[QW-2:0], w_ge};
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_q;

endmodule

>>> rtl/core/depth_bilateral_filter.sv
// Depth bilateral filter, one item at a time through a shared 32x24 multiplier.
// Pixel items are written to the line store and counted; for a result, the centre
// is read, each valid in-image tap of the 7x7 window uses the multiplier, skipped
// taps are passed over, then the divider runs and the output is loaded. Results
// trail input by RADIUS rows plus RADIUS pixels. Synchronous active-low reset
// restores register defaults and counters; the line store is not cleared.
module depth_bilateral_filter
    import dbf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [15:0]       s_axis_tdata,   // [15:0] depth_sample
    input  logic              s_axis_tuser,   // [0] mode
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [15:0]       m_axis_tdata,   // [15:0] filtered_depth
    output logic              m_axis_tlast,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_IW-1:0] i_cfg_index,
    input  logic [CFG_DW-1:0] i_cfg_data
);

    t_state r_state, n_state;

    logic [10:0]      r_width, r_height;
    logic [15:0]      r_sc;
    logic [23:0]      r_dc;
    logic [CW-1:0]    r_w_eff;
    logic [RW-1:0]    r_h_eff;
    logic [CNT_W-1:0] r_total, r_lag;

    logic             r_mode;
    logic [DW-1:0]    r_sample;
    logic [RW-1:0]    r_in_row, r_out_row;
    logic [CW-1:0]    r_in_col, r_out_col;
    logic [SW-1:0]    r_in_slot, r_out_slot;
    logic             r_done;
    logic [CNT_W-1:0] r_in_count, r_out_count;
    logic             r_last;

    logic [DW-1:0]    r_centre, r_v, r_ad;
    logic [TW-1:0]    r_dy, r_dx;
    logic [MP_W-1:0]  r_edep;
    logic [WT_W-1:0]  r_wt;
    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_den;
    logic [QW-1:0]    r_res;

    logic             r_o_valid, r_o_last;
    logic [DW-1:0]    r_o_data;

    // combinational
    logic             w_in_acc, w_out_acc, w_cfg_acc, w_dim_wr;
    logic             w_pix_we, w_fin_load, w_restart, w_defer, w_overrun;
    logic [CW-1:0]    w_w_eff, w_wcol;
    logic [RW-1:0]    w_h_eff;
    logic signed [RW+1:0] w_ty;
    logic signed [CW+1:0] w_tx;
    logic signed [SW+1:0] w_ts_raw, w_ts;
    logic [SW-1:0]    w_tslot;
    logic             w_tap_in, w_tap_last;
    logic signed [D2_W:0] w_dxs, w_dys;
    logic [D2_W-1:0]  w_dist2;
    logic [E_W-1:0]   w_e;
    logic [DW-1:0]    w_rdata, w_absd;

    logic             w_ram_we;
    logic [AW-1:0]    w_waddr, w_raddr;
    logic [MA_W-1:0]  w_ma;
    logic [MB_W-1:0]  w_mb;
    logic [MP_W-1:0]  w_prod;
    logic             w_div_start, w_div_busy;
    logic [QW-1:0]    w_quot;

    assign w_in_acc  = s_axis_tvalid && s_axis_tready;
    assign w_out_acc = r_o_valid && m_axis_tready;
    assign w_cfg_acc = i_cfg_valid && o_cfg_ready;
    assign w_dim_wr  = w_cfg_acc && ((i_cfg_index == CFG_FRAME_WIDTH) ||
                                     (i_cfg_index == CFG_FRAME_HEIGHT));

    assign w_w_eff = (r_width == '0) ? CW'(1) :
                     (int'(r_width) > MAX_WIDTH) ? CW'(MAX_WIDTH) : CW'(r_width);
    assign w_h_eff = (r_height == '0) ? RW'(1) :
                     (int'(r_height) > MAX_HEIGHT) ? RW'(MAX_HEIGHT) : RW'(r_height);

    assign w_pix_we = !r_mode && !r_done;
    assign w_wcol   = (r_in_col >= r_w_eff) ? '0 : r_in_col;

    // tap geometry
    always_comb begin
        w_ty = $signed({2'b00, r_out_row}) + $signed({{(RW+2-TW){1'b0}}, r_dy})
             - (RW+2)'(RADIUS);
        w_tx = $signed({2'b00, r_out_col}) + $signed({{(CW+2-TW){1'b0}}, r_dx})
             - (CW+2)'(RADIUS);
        w_ts_raw = $signed({2'b00, r_out_slot}) + $signed({{(SW+2-TW){1'b0}}, r_dy})
                 - (SW+2)'(RADIUS);
        if (w_ts_raw < 0) begin
            w_ts = w_ts_raw + (SW+2)'(STORE_ROWS);
        end else if (w_ts_raw >= (SW+2)'(STORE_ROWS)) begin
            w_ts = w_ts_raw - (SW+2)'(STORE_ROWS);
        end else begin
            w_ts = w_ts_raw;
        end
        w_tslot  = w_ts[SW-1:0];
        w_tap_in = (w_ty >= 0) && (w_ty < $signed({2'b00, r_h_eff})) &&
                   (w_tx >= 0) && (w_tx < $signed({2'b00, r_w_eff}));
        w_tap_last = (r_dx == TW'(WIN - 1)) && (r_dy == TW'(WIN - 1));
        w_dxs   = $signed({{(D2_W+1-TW){1'b0}}, r_dx}) - (D2_W+1)'(RADIUS);
        w_dys   = $signed({{(D2_W+1-TW){1'b0}}, r_dy}) - (D2_W+1)'(RADIUS);
        w_dist2 = D2_W'(w_dxs * w_dxs + w_dys * w_dys);
    end

    assign w_absd = (w_rdata > r_centre) ? (w_rdata - r_centre) : (r_centre - w_rdata);
    assign w_e    = E_W'(r_edep) + (E_W'(w_prod) << 8);

    assign w_defer   = !r_done && ({1'b0, r_in_count} < ({1'b0, r_out_count} + {1'b0, r_lag}));
    assign w_overrun = (r_out_count >= r_total);
    assign w_fin_load = (r_state == ST_FIN) && (!r_o_valid || w_out_acc);
    assign w_restart = w_dim_wr ||
                       ((r_state == ST_DECIDE) && !w_defer && w_overrun) ||
                       (w_fin_load && r_last);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (w_in_acc) n_state = ST_WRITE;
            ST_WRITE:  n_state = ST_COUNT;
            ST_COUNT:  n_state = ST_DECIDE;
            ST_DECIDE: n_state = (w_defer || w_overrun) ? ST_IDLE : ST_CREAD;
            ST_CREAD:  n_state = ST_CDATA;
            ST_CDATA:  n_state = (w_rdata == '0) ? ST_FIN : ST_TADDR;
            ST_TADDR: begin
                if (w_tap_in)        n_state = ST_TDATA;
                else if (w_tap_last) n_state = ST_DIV;
            end
            ST_TDATA: begin
                if (w_rdata != '0)   n_state = ST_TSQ;
                else if (w_tap_last) n_state = ST_DIV;
                else                 n_state = ST_TADDR;
            end
            ST_TSQ:    n_state = ST_TDEP;
            ST_TDEP:   n_state = ST_TSPA;
            ST_TSPA:   n_state = ST_TLUT;
            ST_TLUT:   n_state = ST_TMUL;
            ST_TMUL:   n_state = ST_TACC;
            ST_TACC:   n_state = w_tap_last ? ST_DIV : ST_TADDR;
            ST_DIV:    n_state = ST_DWAIT;
            ST_DWAIT:  if (!w_div_busy) n_state = ST_FIN;
            ST_FIN:    if (w_fin_load) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // datapath controls
    always_comb begin
        s_axis_tready = 1'b0;
        w_ram_we      = 1'b0;
        w_waddr       = store_addr(r_in_slot, w_wcol);
        w_raddr       = store_addr(w_tslot, CW'(w_tx));
        w_ma          = '0;
        w_mb          = '0;
        w_div_start   = 1'b0;
        case (r_state)
            ST_IDLE:  s_axis_tready = 1'b1;
            ST_WRITE: w_ram_we = w_pix_we;
            ST_CREAD: w_raddr = store_addr(r_out_slot, r_out_col);
            ST_TSQ: begin
                w_ma = MA_W'(r_ad);
                w_mb = MB_W'(r_ad);
            end
            ST_TDEP: begin
                w_ma = w_prod[MA_W-1:0];
                w_mb = r_dc;
            end
            ST_TSPA: begin
                w_ma = MA_W'(w_dist2);
                w_mb = MB_W'(r_sc);
            end
            ST_TMUL: begin
                w_ma = MA_W'(r_wt);
                w_mb = MB_W'(r_v);
            end
            ST_DIV:   w_div_start = 1'b1;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RST_FRAME_WIDTH;
            r_height <= RST_FRAME_HEIGHT;
            r_sc     <= RST_SPATIAL_COEFF;
            r_dc     <= RST_DEPTH_COEFF;
            r_w_eff  <= CW'(1);
            r_h_eff  <= RW'(1);
            r_total  <= CNT_W'(1);
            r_lag    <= '0;
        end else begin
            if (w_cfg_acc) begin
                case (i_cfg_index)
                    CFG_FRAME_WIDTH:   r_width  <= i_cfg_data[10:0];
                    CFG_FRAME_HEIGHT:  r_height <= i_cfg_data[10:0];
                    CFG_SPATIAL_COEFF: r_sc     <= i_cfg_data[15:0];
                    CFG_DEPTH_COEFF:   r_dc     <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            r_w_eff <= w_w_eff;
            r_h_eff <= w_h_eff;
            r_total <= CNT_W'(r_w_eff) * CNT_W'(r_h_eff);
            r_lag   <= CNT_W'(r_w_eff) * CNT_W'(RADIUS) + CNT_W'(RADIUS + 1);
        end
    end

    // frame position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_restart) begin
            r_in_row   <= '0;
            r_in_col   <= '0;
            r_in_slot  <= '0;
            r_out_row  <= '0;
            r_out_col  <= '0;
            r_out_slot <= '0;
            r_done     <= 1'b0;
        end else begin
            if ((r_state == ST_WRITE) && w_pix_we) begin
                if (w_wcol + CW'(1) >= r_w_eff) begin
                    r_in_col  <= '0;
                    r_in_row  <= r_in_row + RW'(1);
                    r_in_slot <= (r_in_slot == SW'(STORE_ROWS - 1)) ? '0 : r_in_slot + SW'(1);
                    if (r_in_row + RW'(1) >= r_h_eff) r_done <= 1'b1;
                end else begin
                    r_in_col <= w_wcol + CW'(1);
                end
            end
            if (w_fin_load) begin
                if (r_out_col + CW'(1) >= r_w_eff) begin
                    r_out_col  <= '0;
                    r_out_row  <= r_out_row + RW'(1);
                    r_out_slot <= (r_out_slot == SW'(STORE_ROWS - 1)) ? '0 :
                                  r_out_slot + SW'(1);
                end else begin
                    r_out_col <= r_out_col + CW'(1);
                end
            end
        end
    end

    // item datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_mode   <= s_axis_tuser;
                r_sample <= s_axis_tdata;
            end
            ST_COUNT: begin
                r_in_count  <= r_done ? r_total :
                               CNT_W'(r_in_row) * CNT_W'(r_w_eff) + CNT_W'(r_in_col);
                r_out_count <= CNT_W'(r_out_row) * CNT_W'(r_w_eff) + CNT_W'(r_out_col);
            end
            ST_DECIDE: r_last <= (r_out_count == r_total - CNT_W'(1));
            ST_CDATA: begin
                r_centre <= w_rdata;
                r_res    <= '0;
                r_dx     <= '0;
                r_dy     <= '0;
                r_num    <= '0;
                r_den    <= '0;
            end
            ST_TADDR: begin
                if (!w_tap_in && !w_tap_last) begin
                    if (r_dx == TW'(WIN - 1)) begin
                        r_dx <= '0;
                        r_dy <= r_dy + TW'(1);
                    end else begin
                        r_dx <= r_dx + TW'(1);
                    end
                end
            end
            ST_TDATA: begin
                r_v  <= w_rdata;
                r_ad <= w_absd;
                if ((w_rdata == '0) && !w_tap_last) begin
                    if (r_dx == TW'(WIN - 1)) begin
                        r_dx <= '0;
                        r_dy <= r_dy + TW'(1);
                    end else begin
                        r_dx <= r_dx + TW'(1);
                    end
                end
            end
            ST_TSPA: r_edep <= w_prod;
            // weight is zero once the exponent reaches 16.0 in Q.24
            ST_TLUT: r_wt <= (w_e >= (E_W'(1) << E_LIMIT_BIT)) ? '0 :
                             EXP_ROM[w_e[E_LIMIT_BIT-1 -: EB]];
            ST_TACC: begin
                r_num <= r_num + NUM_W'(w_prod);
                r_den <= r_den + DEN_W'(r_wt);
                if (!w_tap_last) begin
                    if (r_dx == TW'(WIN - 1)) begin
                        r_dx <= '0;
                        r_dy <= r_dy + TW'(1);
                    end else begin
                        r_dx <= r_dx + TW'(1);
                    end
                end
            end
            ST_DWAIT: r_res <= w_quot;
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_fin_load) begin
            r_o_valid <= 1'b1;
        end else if (w_out_acc) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fin_load) begin
            r_o_data <= r_res;
            r_o_last <= r_last;
        end
    end

    dbf_ram #(
        .WIDTH (DW),
        .DEPTH (STORE_ROWS * MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_waddr),
        .i_wdata (r_sample),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    dbf_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_ma),
        .i_b   (w_mb),
        .o_p   (w_prod)
    );

    dbf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_busy  (w_div_busy),
        .o_quot  (w_quot)
    );

    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_data;
    assign m_axis_tlast  = r_o_last;

endmodule
